[hdl/rflmf_pkg.sv]
`timescale 1ns / 1ps

package rflmf_pkg;

	localparam int unsigned MAC_BYTES = 6;
	localparam int unsigned MAC_W = 8 * MAC_BYTES;
	localparam logic [15:0] HDR_BYTES = 16'd2;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1514;
	localparam logic [2:0] MAC_LAST = 3'(MAC_BYTES);

	// register indexes on the configuration port
	localparam logic CFG_LOCAL_MAC = 1'b0;
	localparam logic CFG_MAX_PAYLOAD = 1'b1;

	typedef enum logic [2:0] {
		ST_NONE = 3'd0,
		ST_ACCEPT = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_OVERSIZE = 3'd3,
		ST_BADHDR = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic data_valid;
		logic frame_end;
		status_t frame_status;
		logic [15:0] frame_length;
	} res_t;

endpackage

[hdl/rflmf_parser.sv]
`timescale 1ns / 1ps

module rflmf_parser (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [rflmf_pkg::MAC_W-1:0] cfg_data,
	input logic step,
	input logic [7:0] rx_byte,
	output rflmf_pkg::res_t res
);

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	logic [rflmf_pkg::MAC_W-1:0] local_mac_q;
	logic [15:0] max_payload_q;

	phase_t phase_q, phase_d;
	logic [7:0] header_high_q, header_high_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [15:0] payload_total_q, payload_total_d;
	logic [2:0] mac_index_q, mac_index_d;
	logic mac_equal_q, mac_equal_d;
	logic group_q, group_d;
	logic dropping_q, dropping_d;

	logic [15:0] hv;
	logic [15:0] plen;
	logic [7:0] mac_byte;

	assign hv = {header_high_q, rx_byte};
	assign plen = hv - rflmf_pkg::HDR_BYTES;

	always_comb begin
		case (mac_index_q)
			3'd0: mac_byte = local_mac_q[47:40];
			3'd1: mac_byte = local_mac_q[39:32];
			3'd2: mac_byte = local_mac_q[31:24];
			3'd3: mac_byte = local_mac_q[23:16];
			3'd4: mac_byte = local_mac_q[15:8];
			3'd5: mac_byte = local_mac_q[7:0];
			default: mac_byte = 8'd0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		header_high_d = header_high_q;
		bytes_left_d = bytes_left_q;
		payload_total_d = payload_total_q;
		mac_index_d = mac_index_q;
		mac_equal_d = mac_equal_q;
		group_d = group_q;
		dropping_d = dropping_q;
		res = '{data_byte: 8'd0, data_valid: 1'b0, frame_end: 1'b0,
			frame_status: rflmf_pkg::ST_NONE, frame_length: 16'd0};

		case (phase_q)
			PH_LOW: begin
				if (hv < rflmf_pkg::HDR_BYTES) begin
					res.frame_end = 1'b1;
					res.frame_status = rflmf_pkg::ST_BADHDR;
					phase_d = PH_HIGH;
				end else begin
					mac_index_d = 3'd0;
					mac_equal_d = 1'b1;
					group_d = 1'b0;
					bytes_left_d = plen;
					payload_total_d = plen;
					if (plen == 16'd0) begin
						res.frame_end = 1'b1;
						res.frame_status = rflmf_pkg::ST_MISMATCH;
						dropping_d = 1'b0;
						phase_d = PH_HIGH;
					end else begin
						dropping_d = (plen > max_payload_q);
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (!dropping_q) begin
					res.data_valid = 1'b1;
					res.data_byte = rx_byte;
					if (mac_index_q == 3'd0)
						group_d = rx_byte[0];
					if (mac_index_q < rflmf_pkg::MAC_LAST) begin
						if (rx_byte != mac_byte)
							mac_equal_d = 1'b0;
						mac_index_d = mac_index_q + 3'd1;
					end
				end
				bytes_left_d = bytes_left_q - 16'd1;
				if (bytes_left_d == 16'd0) begin
					res.frame_end = 1'b1;
					res.frame_length = payload_total_q;
					if (dropping_q)
						res.frame_status = rflmf_pkg::ST_OVERSIZE;
					else if (group_d || (mac_index_d == rflmf_pkg::MAC_LAST && mac_equal_d))
						res.frame_status = rflmf_pkg::ST_ACCEPT;
					else
						res.frame_status = rflmf_pkg::ST_MISMATCH;
					phase_d = PH_HIGH;
				end
			end
			default: begin
				// the unused phase code behaves as the high header byte
				header_high_d = rx_byte;
				phase_d = PH_LOW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mac_q <= '0;
			max_payload_q <= rflmf_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rflmf_pkg::CFG_LOCAL_MAC: local_mac_q <= cfg_data;
				rflmf_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HIGH;
			header_high_q <= 8'd0;
			bytes_left_q <= 16'd0;
			payload_total_q <= 16'd0;
			mac_index_q <= 3'd0;
			mac_equal_q <= 1'b1;
			group_q <= 1'b0;
			dropping_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			header_high_q <= header_high_d;
			bytes_left_q <= bytes_left_d;
			payload_total_q <= payload_total_d;
			mac_index_q <= mac_index_d;
			mac_equal_q <= mac_equal_d;
			group_q <= group_d;
			dropping_q <= dropping_d;
		end
	end

endmodule

[hdl/rflmf_out_buf.sv]
`timescale 1ns / 1ps

module rflmf_out_buf (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rflmf_pkg::res_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rflmf_pkg::res_t out_data
);

	logic out_valid_q;
	logic skid_valid_q;
	rflmf_pkg::res_t out_q;
	rflmf_pkg::res_t skid_q;
	logic push;
	logic load;

	// stall comes straight from a flop, so upstream never sees out_stall combinationally
	assign in_stall = skid_valid_q;
	assign push = in_valid && !skid_valid_q;
	assign load = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end

endmodule

[hdl/raw_frame_length_and_mac_filter.sv]
`timescale 1ns / 1ps
// Each accepted byte's result beat is registered in the output buffer; the parser state
// updates in the cycle of acceptance. Throughput: one byte per cycle while rx_stall is low.
// A two-entry output buffer (result register plus skid) keeps rx_stall a flop output.
// Reset: parser waits for a high header byte, local_mac is 0, max_payload is 1514,
// output buffer empty.

module raw_frame_length_and_mac_filter (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [rflmf_pkg::MAC_W-1:0] cfg_data,
	input logic rx_valid,
	output logic rx_stall,
	input logic [7:0] rx_byte,
	output logic res_valid,
	input logic res_stall,
	output logic [7:0] data_byte,
	output logic data_valid,
	output logic frame_end,
	output logic [2:0] frame_status,
	output logic [15:0] frame_length
);

	logic step;
	rflmf_pkg::res_t res;
	rflmf_pkg::res_t res_out;

	assign step = rx_valid && !rx_stall;

	rflmf_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step(step),
		.rx_byte(rx_byte),
		.res(res)
	);

	rflmf_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rx_valid),
		.in_stall(rx_stall),
		.in_data(res),
		.out_valid(res_valid),
		.out_stall(res_stall),
		.out_data(res_out)
	);

	assign data_byte = res_out.data_byte;
	assign data_valid = res_out.data_valid;
	assign frame_end = res_out.frame_end;
	assign frame_status = res_out.frame_status;
	assign frame_length = res_out.frame_length;

endmodule

[hdl/rflmf_checker.sv]
`timescale 1ns / 1ps

module rflmf_checker (
	input logic clk,
	input logic arst_n,
	input logic rx_stall,
	input logic res_valid,
	input logic res_stall,
	input logic [7:0] data_byte,
	input logic data_valid,
	input logic frame_end,
	input logic [2:0] frame_status,
	input logic [15:0] frame_length
);

	// a held result beat must not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(data_byte) && $stable(data_valid)
			&& $stable(frame_end) && $stable(frame_status) && $stable(frame_length))
		else $error("result beat changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (frame_end == (frame_status != rflmf_pkg::ST_NONE)))
		else $error("frame_status disagrees with frame_end");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_end |-> frame_length == 16'd0)
		else $error("frame_length set off a frame end");

	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !data_valid |-> data_byte == 8'd0)
		else $error("data_byte set on a non-payload beat");

	// input only stalls when both buffer entries hold results
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid)
		else $error("input stalled with empty output");

endmodule

bind raw_frame_length_and_mac_filter rflmf_checker u_rflmf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rx_stall(rx_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.data_byte(data_byte),
	.data_valid(data_valid),
	.frame_end(frame_end),
	.frame_status(frame_status),
	.frame_length(frame_length)
);
